@@ rtl/core/random_blink_look_scheduler_core_defines.svh @@
// assertion helpers shared by the scheduler core
`ifndef RANDOM_BLINK_LOOK_SCHEDULER_CORE_DEFINES_SVH
`define RANDOM_BLINK_LOOK_SCHEDULER_CORE_DEFINES_SVH

// same-cycle implication
`define RBLS_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("rbls check failed");

// next-cycle implication
`define RBLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("rbls check failed");

`endif

@@ rtl/core/rbls_pkg.sv @@
`timescale 1ns / 1ps
package rbls_pkg;

  localparam int DATA_W    = 32;
  localparam int STATE_W   = 4;
  localparam int CFG_IDX_W = 3;

  localparam int STATE_COUNT_DEF = 8;
  localparam int IDLE_STATE_DEF  = 0;

  localparam logic [DATA_W-1:0] LCG_MUL = 32'd1664525;
  localparam logic [DATA_W-1:0] LCG_ADD = 32'd1013904223;

  localparam logic [DATA_W-1:0] BLINK_MIN_RST = 32'd2000;
  localparam logic [DATA_W-1:0] BLINK_MAX_RST = 32'd6000;
  localparam logic [DATA_W-1:0] LOOK_INACT_RST = 32'd10000;
  localparam logic [DATA_W-1:0] LOOK_MIN_RST  = 32'd3000;
  localparam logic [DATA_W-1:0] LOOK_MAX_RST  = 32'd8000;
  localparam logic [DATA_W-1:0] SEED_RST      = 32'd1;

  localparam logic [CFG_IDX_W-1:0] REG_BLINK_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_INACT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_MIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LOOK_MAX   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED       = 3'd5;

  function automatic logic [DATA_W-1:0] sat_add(input logic [DATA_W-1:0] a,
                                                input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? '1 : s[DATA_W-1:0];
  endfunction

endpackage

@@ rtl/core/rbls_rem.sv @@
`timescale 1ns / 1ps
module rbls_rem import rbls_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] rem
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] sh_r;
  logic [DATA_W-1:0] dv_r;
  logic [DATA_W:0]   trial;

  assign trial = {rem_r, sh_r[DATA_W-1]};
  assign done  = done_r;
  assign rem   = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      sh_r  <= dividend;
      dv_r  <= divisor;
    end else if (busy_r) begin
      sh_r <= {sh_r[DATA_W-2:0], 1'b0};
      if (trial >= {1'b0, dv_r}) begin
        rem_r <= DATA_W'(trial - {1'b0, dv_r});
      end else begin
        rem_r <= trial[DATA_W-1:0];
      end
    end
  end

endmodule

@@ rtl/core/random_blink_look_scheduler_core.sv @@
`timescale 1ns / 1ps
// Random blink and look scheduler. Each item (now time, last activity time,
// activity state) yields exactly one result item. The block takes one item at
// a time and holds in_stall high until its result has been taken. An item with
// an out-of-range state is passed straight to the result; otherwise blink and
// look may be rescheduled, and a look event draws a third random delay. Each
// random delay that needs a modulo waits on the bit-serial remainder unit.
// A configuration write restarts the scheduler state.
`include "random_blink_look_scheduler_core_defines.svh"
module random_blink_look_scheduler_core import rbls_pkg::*; #(
  parameter int STATE_COUNT = STATE_COUNT_DEF,
  parameter int IDLE_STATE  = IDLE_STATE_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [DATA_W-1:0]    in_now_time,
  input  logic [DATA_W-1:0]    in_last_activity_time,
  input  logic [STATE_W-1:0]   in_activity_state,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_event_valid,
  output logic                 out_event_kind,
  output logic                 out_look_side,
  output logic [DATA_W-1:0]    out_event_time
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_EVAL   = 11'b000_0000_0010,
    S_PLAN   = 11'b000_0000_0100,
    S_RAND   = 11'b000_0000_1000,
    S_DSTART = 11'b000_0001_0000,
    S_DIV    = 11'b000_0010_0000,
    S_FIN1   = 11'b000_0100_0000,
    S_FIN2   = 11'b000_1000_0000,
    S_CHECK  = 11'b001_0000_0000,
    S_SIDE   = 11'b010_0000_0000,
    S_OUT    = 11'b100_0000_0000
  } state_t;

  localparam logic [STATE_W-1:0] ST_NONE = STATE_W'(STATE_COUNT);
  localparam logic [STATE_W-1:0] ST_IDLE = STATE_W'(IDLE_STATE);

  state_t state_r;

  logic [DATA_W-1:0] bmin_r, bmax_r, inact_r, lmin_r, lmax_r, seed_r;

  logic [STATE_W-1:0] seen_state_r;
  logic [DATA_W-1:0]  seen_act_r;
  logic [DATA_W-1:0]  lcg_r;
  logic [DATA_W-1:0]  blink_due_r;
  logic [DATA_W-1:0]  look_due_r;
  logic               armed_r;

  logic [DATA_W-1:0]  now_r, act_r, idle_for_r, left_r;
  logic [STATE_W-1:0] st_r;
  logic               inact_ok_r;
  logic               pend_b_r, pend_l_r, after_check_r, tgt_look_r;
  logic [DATA_W-1:0]  lo_r, span_r, rnd_r, delay_r;

  logic               ev_valid_r, ev_kind_r, side_r;
  logic [DATA_W-1:0]  ev_time_r;

  logic [DATA_W-1:0]  lcg_nxt;
  logic [DATA_W-1:0]  seed_eff;
  logic               st_chg, act_chg, replan;
  logic [DATA_W-1:0]  look_diff, blink_diff;
  logic               div_start, div_done;
  logic [DATA_W-1:0]  div_rem;

  assign lcg_nxt    = DATA_W'(lcg_r * LCG_MUL) + LCG_ADD;
  assign seed_eff   = (cfg_index == REG_SEED) ? cfg_wdata : seed_r;
  assign st_chg     = st_r != seen_state_r;
  assign act_chg    = act_r != seen_act_r;
  assign replan     = (st_chg || act_chg) && (st_r == ST_IDLE);
  assign look_diff  = now_r - look_due_r;
  assign blink_diff = now_r - blink_due_r;
  assign div_start  = (state_r == S_DSTART) && (span_r != '1);

  rbls_rem u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (rnd_r),
    .divisor  (span_r + 1'b1),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign in_stall        = state_r != S_IDLE;
  assign out_valid       = state_r == S_OUT;
  assign out_event_valid = ev_valid_r;
  assign out_event_kind  = ev_kind_r;
  assign out_look_side   = side_r;
  assign out_event_time  = ev_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      bmin_r        <= BLINK_MIN_RST;
      bmax_r        <= BLINK_MAX_RST;
      inact_r       <= LOOK_INACT_RST;
      lmin_r        <= LOOK_MIN_RST;
      lmax_r        <= LOOK_MAX_RST;
      seed_r        <= SEED_RST;
      seen_state_r  <= ST_NONE;
      seen_act_r    <= '0;
      lcg_r         <= SEED_RST;
      blink_due_r   <= '0;
      look_due_r    <= '0;
      armed_r       <= 1'b0;
      pend_b_r      <= 1'b0;
      pend_l_r      <= 1'b0;
      after_check_r <= 1'b0;
      tgt_look_r    <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (cfg_wr_en && cfg_index <= REG_SEED) begin
            unique case (cfg_index)
              REG_BLINK_MIN:  bmin_r  <= cfg_wdata;
              REG_BLINK_MAX:  bmax_r  <= cfg_wdata;
              REG_LOOK_INACT: inact_r <= cfg_wdata;
              REG_LOOK_MIN:   lmin_r  <= cfg_wdata;
              REG_LOOK_MAX:   lmax_r  <= cfg_wdata;
              default:        seed_r  <= cfg_wdata;
            endcase
            seen_state_r <= ST_NONE;
            seen_act_r   <= '0;
            lcg_r        <= (seed_eff == '0) ? DATA_W'(1) : seed_eff;
            blink_due_r  <= '0;
            look_due_r   <= '0;
            armed_r      <= 1'b0;
          end
          if (in_valid) begin
            state_r <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (st_r >= ST_NONE) begin
            state_r <= S_OUT;
          end else begin
            if (st_chg) begin
              seen_state_r <= st_r;
            end
            if (act_chg) begin
              seen_act_r <= act_r;
            end
            armed_r       <= replan ? 1'b1 : (st_chg ? 1'b0 : armed_r);
            pend_b_r      <= replan;
            pend_l_r      <= replan;
            after_check_r <= 1'b1;
            state_r       <= S_PLAN;
          end
        end
        S_PLAN: begin
          if (pend_b_r) begin
            pend_b_r   <= 1'b0;
            tgt_look_r <= 1'b0;
            state_r    <= S_RAND;
          end else if (pend_l_r) begin
            pend_l_r   <= 1'b0;
            tgt_look_r <= 1'b1;
            state_r    <= S_RAND;
          end else if (after_check_r) begin
            state_r <= S_CHECK;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_RAND: begin
          if (span_r == '0) begin
            state_r <= S_FIN1;
          end else begin
            lcg_r   <= lcg_nxt;
            state_r <= S_DSTART;
          end
        end
        S_DSTART: begin
          state_r <= (span_r == '1) ? S_FIN1 : S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_FIN1;
          end
        end
        S_FIN1: begin
          state_r <= S_FIN2;
        end
        S_FIN2: begin
          if (tgt_look_r) begin
            look_due_r <= sat_add(now_r, delay_r);
          end else begin
            blink_due_r <= sat_add(now_r, delay_r);
          end
          state_r <= S_PLAN;
        end
        S_CHECK: begin
          after_check_r <= 1'b0;
          if (st_r != ST_IDLE || !armed_r) begin
            state_r <= S_OUT;
          end else if (inact_ok_r && !look_diff[DATA_W-1]) begin
            state_r <= S_SIDE;
          end else if (!blink_diff[DATA_W-1]) begin
            pend_b_r <= 1'b1;
            state_r  <= S_PLAN;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_SIDE: begin
          lcg_r    <= lcg_nxt;
          pend_l_r <= 1'b1;
          state_r  <= S_PLAN;
        end
        S_OUT: begin
          if (!out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item data path
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        now_r      <= in_now_time;
        act_r      <= in_last_activity_time;
        st_r       <= in_activity_state;
        idle_for_r <= in_now_time - in_last_activity_time;
      end
      S_EVAL: begin
        inact_ok_r <= idle_for_r >= inact_r;
        left_r     <= (idle_for_r < inact_r) ? inact_r - idle_for_r : '0;
        ev_valid_r <= 1'b0;
        ev_kind_r  <= 1'b0;
        side_r     <= 1'b0;
        ev_time_r  <= '0;
      end
      S_PLAN: begin
        lo_r   <= pend_b_r ? bmin_r : lmin_r;
        span_r <= pend_b_r ? bmax_r - bmin_r : lmax_r - lmin_r;
      end
      S_RAND: begin
        rnd_r   <= lcg_nxt;
        delay_r <= lo_r;
      end
      S_DSTART: begin
        delay_r <= lo_r + rnd_r;
      end
      S_DIV: begin
        delay_r <= lo_r + div_rem;
      end
      S_FIN1: begin
        if (tgt_look_r) begin
          delay_r <= sat_add(left_r, delay_r);
        end
      end
      S_CHECK: begin
        if (st_r == ST_IDLE && armed_r) begin
          if (inact_ok_r && !look_diff[DATA_W-1]) begin
            ev_valid_r <= 1'b1;
            ev_kind_r  <= 1'b1;
            ev_time_r  <= now_r;
          end else if (!blink_diff[DATA_W-1]) begin
            ev_valid_r <= 1'b1;
            ev_time_r  <= now_r;
          end
        end
      end
      S_SIDE: begin
        side_r <= lcg_nxt[0];
      end
      default: ;
    endcase
  end

  `RBLS_ASSERT_NOW(a_quiet_zero, clk, rst_n, out_valid && !out_event_valid, !out_event_kind && !out_look_side && out_event_time == '0)
  `RBLS_ASSERT_NOW(a_blink_side, clk, rst_n, out_valid && out_event_valid && !out_event_kind, !out_look_side)
  `RBLS_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall && !out_valid)

endmodule

@@ tb/random_blink_look_scheduler_core_test.sv @@
`timescale 1ns / 1ps
module random_blink_look_scheduler_core_test;
  import rbls_pkg::*;

  typedef struct packed {
    logic [DATA_W-1:0]  now_time;
    logic [DATA_W-1:0]  act_time;
    logic [STATE_W-1:0] state;
  } upd_t;

  typedef struct packed {
    logic              ev_valid;
    logic              ev_kind;
    logic              side;
    logic [DATA_W-1:0] ev_time;
  } evt_t;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [DATA_W-1:0] in_now_time;
  logic [DATA_W-1:0] in_last_activity_time;
  logic [STATE_W-1:0] in_activity_state;
  logic out_valid;
  logic out_stall;
  logic out_event_valid;
  logic out_event_kind;
  logic out_look_side;
  logic [DATA_W-1:0] out_event_time;

  random_blink_look_scheduler_core dut (.*);

  // predictor state
  logic [DATA_W-1:0] p_cfg [6];
  logic [STATE_W-1:0] p_seen_state;
  logic [DATA_W-1:0] p_seen_act, p_lcg, p_blink_due, p_look_due;
  logic p_armed;

  upd_t pending_items[$];
  evt_t expected_events[$];
  int errors = 0;
  int n_events = 0;
  int n_looks = 0;
  int n_checked = 0;
  bit hold_off = 0;
  bit long_hold = 0;

  function automatic logic [DATA_W-1:0] sat_sum(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? {DATA_W{1'b1}} : s[DATA_W-1:0];
  endfunction

  function automatic bit is_due(logic [DATA_W-1:0] now, logic [DATA_W-1:0] due);
    logic [DATA_W-1:0] d;
    d = now - due;
    return !d[DATA_W-1];
  endfunction

  function automatic logic [DATA_W-1:0] next_rand();
    p_lcg = p_lcg * LCG_MUL + LCG_ADD;
    return p_lcg;
  endfunction

  function automatic logic [DATA_W-1:0] rand_delay(logic [DATA_W-1:0] lo,
                                                   logic [DATA_W-1:0] hi);
    logic [DATA_W-1:0] span, r, m;
    span = hi - lo;
    if (span == 0) return lo;
    r = next_rand();
    m = span + 1;
    if (m == 0) return lo + r;
    return lo + r % m;
  endfunction

  function automatic void sched_blink(logic [DATA_W-1:0] now);
    p_blink_due = sat_sum(now, rand_delay(p_cfg[REG_BLINK_MIN], p_cfg[REG_BLINK_MAX]));
  endfunction

  function automatic void sched_look(logic [DATA_W-1:0] now, logic [DATA_W-1:0] act);
    logic [DATA_W-1:0] idle_for, left, d;
    idle_for = now - act;
    left = idle_for < p_cfg[REG_LOOK_INACT] ? p_cfg[REG_LOOK_INACT] - idle_for : 0;
    d = rand_delay(p_cfg[REG_LOOK_MIN], p_cfg[REG_LOOK_MAX]);
    p_look_due = sat_sum(now, sat_sum(left, d));
  endfunction

  function automatic void restart_sched();
    p_seen_state = STATE_COUNT_DEF;
    p_seen_act = 0;
    p_lcg = p_cfg[REG_SEED] == 0 ? 1 : p_cfg[REG_SEED];
    p_blink_due = 0;
    p_look_due = 0;
    p_armed = 0;
  endfunction

  function automatic evt_t predict_event(upd_t u);
    evt_t e;
    bit st_chg, act_chg;
    e = '0;
    if (u.state >= STATE_COUNT_DEF) return e;
    st_chg = u.state != p_seen_state;
    act_chg = u.act_time != p_seen_act;
    if (st_chg) begin
      p_seen_state = u.state;
      p_armed = 0;
    end
    if (act_chg) p_seen_act = u.act_time;
    if ((st_chg || act_chg) && u.state == IDLE_STATE_DEF) begin
      p_armed = 1;
      sched_blink(u.now_time);
      sched_look(u.now_time, u.act_time);
    end
    if (u.state != IDLE_STATE_DEF || !p_armed) return e;
    if (u.now_time - u.act_time >= p_cfg[REG_LOOK_INACT] && is_due(u.now_time, p_look_due)) begin
      e.ev_valid = 1;
      e.ev_kind = 1;
      e.side = next_rand() & 1;
      e.ev_time = u.now_time;
      sched_look(u.now_time, u.act_time);
      return e;
    end
    if (is_due(u.now_time, p_blink_due)) begin
      e.ev_valid = 1;
      e.ev_time = u.now_time;
      sched_blink(u.now_time);
    end
    return e;
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  int in_gap = 0;
  bit drv_bursty = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 0;
    end else if (in_valid && !in_stall) begin
      expected_events.push_back(predict_event(pending_items.pop_front()));
      in_gap = drv_bursty ? 0 : gap_len();
      if (in_gap == 0 && pending_items.size() > 0 && !hold_off) begin
        in_now_time <= pending_items[0].now_time;
        in_last_activity_time <= pending_items[0].act_time;
        in_activity_state <= pending_items[0].state;
      end else begin
        in_valid <= 0;
      end
    end else if (!in_valid) begin
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_items.size() > 0 && !hold_off) begin
        in_valid <= 1;
        in_now_time <= pending_items[0].now_time;
        in_last_activity_time <= pending_items[0].act_time;
        in_activity_state <= pending_items[0].state;
      end
    end
  end

  // monitor
  int out_gap = 0;
  int hold_cnt = 0;
  bit rx_bursty = 0;
  always @(posedge clk) begin
    evt_t e;
    if (!rst_n) begin
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_checked++;
        if (expected_events.size() == 0) begin
          $error("result item with no expectation");
          errors++;
        end else begin
          e = expected_events.pop_front();
          if (out_event_valid !== e.ev_valid) begin
            $error("event_valid exp %0h got %0h", e.ev_valid, out_event_valid);
            errors++;
          end
          if (out_event_kind !== e.ev_kind) begin
            $error("event_kind exp %0h got %0h", e.ev_kind, out_event_kind);
            errors++;
          end
          if (out_look_side !== e.side) begin
            $error("look_side exp %0h got %0h", e.side, out_look_side);
            errors++;
          end
          if (out_event_time !== e.ev_time) begin
            $error("event_time exp %0h got %0h", e.ev_time, out_event_time);
            errors++;
          end
          if (e.ev_valid) n_events++;
          if (e.ev_valid && e.ev_kind) n_looks++;
        end
      end
      if (long_hold) begin
        hold_cnt = 400;
        long_hold = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1;
      end else if (rx_bursty) begin
        out_stall <= 0;
      end else if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1;
      end else begin
        out_gap = gap_len();
        out_stall <= out_gap > 0;
      end
    end
  end

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 0;
    p_cfg[idx] = val;
    restart_sched();
  endtask

  task automatic wait_drained();
    while (pending_items.size() > 0 || expected_events.size() > 0 || in_valid) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic upd_t noise_item();
    upd_t u;
    u.now_time = $urandom();
    u.act_time = $urandom();
    u.state = $urandom_range(0, 15);
    return u;
  endfunction

  // idle sessions with time rising by up to step_max per item, so blinks and looks really fire
  task automatic add_session(int n, logic [DATA_W-1:0] t0, int step_max);
    logic [DATA_W-1:0] t, act;
    int r;
    t = t0;
    act = t0 - $urandom_range(0, 20);
    for (int i = 0; i < n; i++) begin
      upd_t u;
      r = $urandom_range(0, 99);
      t = t + $urandom_range(0, step_max);
      if (r < 3) act = t;
      u.now_time = t;
      u.act_time = act;
      u.state = IDLE_STATE_DEF;
      if (r >= 97) u.state = $urandom_range(1, 7);
      else if (r == 96) u.state = $urandom_range(8, 15);
      else if (r == 95) u = noise_item();
      pending_items.push_back(u);
    end
  endtask

  task automatic set_cfg(logic [DATA_W-1:0] bmin, logic [DATA_W-1:0] bmax,
                         logic [DATA_W-1:0] li, logic [DATA_W-1:0] lmin,
                         logic [DATA_W-1:0] lmax, logic [DATA_W-1:0] seed);
    cfg_write(REG_BLINK_MIN, bmin);
    cfg_write(REG_BLINK_MAX, bmax);
    cfg_write(REG_LOOK_INACT, li);
    cfg_write(REG_LOOK_MIN, lmin);
    cfg_write(REG_LOOK_MAX, lmax);
    cfg_write(REG_SEED, seed);
  endtask

  initial begin
    upd_t u;
    rst_n = 0;
    cfg_wr_en = 0;
    cfg_index = 0;
    cfg_wdata = 0;
    in_valid = 0;
    in_now_time = 0;
    in_last_activity_time = 0;
    in_activity_state = 0;
    out_stall = 0;
    p_cfg[REG_BLINK_MIN] = BLINK_MIN_RST;
    p_cfg[REG_BLINK_MAX] = BLINK_MAX_RST;
    p_cfg[REG_LOOK_INACT] = LOOK_INACT_RST;
    p_cfg[REG_LOOK_MIN] = LOOK_MIN_RST;
    p_cfg[REG_LOOK_MAX] = LOOK_MAX_RST;
    p_cfg[REG_SEED] = SEED_RST;
    restart_sched();
    repeat (2) @(posedge clk);
    rst_n <= 1;

    // directed items under reset settings
    pending_items.push_back('{32'd0, 32'd0, 4'd0});
    pending_items.push_back('{32'd0, 32'd0, 4'd0});
    pending_items.push_back('{32'd7000, 32'd0, 4'd0});
    pending_items.push_back('{32'd20000, 32'd0, 4'd0});
    pending_items.push_back('{32'd40000, 32'd0, 4'd0});
    pending_items.push_back('{32'd40001, 32'd0, 4'd15});
    pending_items.push_back('{32'd40002, 32'd0, 4'd8});
    pending_items.push_back('{32'd40003, 32'd5, 4'd7});
    pending_items.push_back('{32'hFFFF_FFF0, 32'hFFFF_FF00, 4'd0});
    pending_items.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd0});
    pending_items.push_back('{32'h0000_0010, 32'hFFFF_FFFF, 4'd0});
    pending_items.push_back('{32'h8000_0000, 32'h0, 4'd0});
    pending_items.push_back('{32'hFFFF_FFFF, 32'h0, 4'd0});
    wait_drained();

    // equal bounds, min above max, full span, zero seed
    set_cfg(32'd5, 32'd5, 32'd1, 32'd7, 32'd7, 32'd0);
    for (int i = 0; i < 6; i++) pending_items.push_back('{32'(i * 6), 32'd0, 4'd0});
    wait_drained();
    set_cfg(32'd9, 32'd3, 32'hFFFF_FFFF, 32'd10, 32'd2, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) pending_items.push_back('{32'(i * 50), 32'd1, 4'd0});
    wait_drained();
    set_cfg(32'd0, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'd0, 32'h1234_5678);
    for (int i = 0; i < 4; i++) pending_items.push_back('{$urandom(), $urandom(), 4'd0});
    wait_drained();

    // random phases
    for (int ph = 0; ph < 12; ph++) begin
      int mode;
      mode = ph % 4;
      if (mode == 0) set_cfg($urandom_range(1, 40), $urandom_range(1, 80),
                             $urandom_range(1, 100), $urandom_range(1, 40),
                             $urandom_range(1, 90), $urandom());
      else if (mode == 1) set_cfg($urandom(), $urandom(), $urandom(), $urandom(),
                                  $urandom(), $urandom());
      else if (mode == 2) set_cfg(32'd1, 32'd1, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'd0);
      else set_cfg($urandom_range(1, 10), 32'hFFFF_FFFF, $urandom_range(1, 30),
                   $urandom_range(1, 10), $urandom_range(10, 50), $urandom());
      drv_bursty = (ph == 5);
      rx_bursty = (ph == 5);
      if (ph == 3) begin
        hold_off = 1;
        add_session(40, $urandom(), 20);
        long_hold = 1;
        hold_off = 0;
      end
      add_session(110, $urandom(), (mode == 1) ? 32'h7FFF_FFFF : 25);
      for (int i = 0; i < 6; i++) pending_items.push_back(noise_item());
      // sender pauses until all results are back
      while (expected_events.size() > 0 || pending_items.size() > 0 || in_valid) @(posedge clk);
      wait_drained();
    end

    $display("checked %0d result items, %0d events of which %0d looks", n_checked,
             n_events, n_looks);
    $display("covered reset, extreme and random settings with stalls on both sides");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

endmodule
